>>> rtl/interval_max_score_projection_assert.svh
// assertion macros for the interval max-score projection block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef INTERVAL_MAX_SCORE_PROJECTION_ASSERT_SVH
`define INTERVAL_MAX_SCORE_PROJECTION_ASSERT_SVH

// property that holds at every clock edge outside reset
`define IMSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("imsp assertion failed");

// property that holds in the cycle after a trigger
`define IMSP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("imsp assertion failed");

`endif

>>> rtl/imsp_pkg.sv
// shared types and constants of the interval max-score projection block
// no dependencies
`timescale 1ns / 1ps

package imsp_pkg;

  localparam int unsigned MAX_PIECES = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_PIECES);
  localparam int unsigned CNT_W      = $clog2(MAX_PIECES + 1);
  localparam int unsigned POS_W      = 32;
  localparam int unsigned SCORE_W    = 32;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD_NEW,
    CMD_SPLIT_S,
    CMD_SPLIT_E,
    CMD_APPEND,
    CMD_RAISE,
    CMD_SHIFT_DN
  } cell_cmd_e;

  typedef struct packed {
    logic        [POS_W-1:0]   lo;
    logic        [POS_W-1:0]   hi;
    logic signed [SCORE_W-1:0] score;
  } piece_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_e                 cmd;
    logic        [CNT_W-1:0]   cnt;
    logic        [POS_W-1:0]   s;
    logic        [POS_W-1:0]   e;
    logic signed [SCORE_W-1:0] sc;
  } cell_ctrl_t;

  // per-cell compare results back to the controller
  typedef struct packed {
    logic ge_s;
    logic hit_s;
    logic split_s;
    logic le_e;
    logic split_e;
  } cell_flag_t;

endpackage

>>> rtl/interval_max_score_projection.sv
// top level of the interval max-score projection block
// depends on imsp_pkg, imsp_cell and interval_max_score_projection_assert.svh
//
// Usage: the input channel (in_valid_i / in_ready_o) takes one request word:
// req_type_i 0 adds the segment seg_start_i..seg_end_i with seg_score_i,
// req_type_i 1 flushes. The output channel (out_valid_o / out_ready_i) gives
// result words. An add gives one word with its status and last_o set. A flush
// gives one word per merged piece in position order, last_o on the final
// one, or one empty word when the list holds nothing.
// One request is worked on at a time; in_ready_o is high only when idle.
// Steps: an add passes decode, start split, end split, append, score
// raise and result; one dropped or appended past the list goes from decode
// straight to result. A flush shifts one piece out of the chain's head cell
// per cycle, pausing while a finished piece waits on a stalled receiver.
// The result sits in an output register; when the receiver stalls, the
// block holds that word and the flush pauses until it is taken.
// Reset empties the list and the output register; stored pieces need no
// clearing since only cells below the piece count are ever used.
`timescale 1ns / 1ps

module interval_max_score_projection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] seg_start_i,
  input  logic [31:0] seg_end_i,
  input  logic signed [31:0] seg_score_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        piece_valid_o,
  output logic [31:0] piece_start_o,
  output logic [31:0] piece_end_o,
  output logic signed [31:0] piece_score_o,
  output logic        last_o
);
  import imsp_pkg::*;

  `include "interval_max_score_projection_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_SPLIT_S, S_SPLIT_E, S_APPEND, S_RAISE, S_EMIT,
    S_FL_START, S_FL_RUN
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [POS_W-1:0]          s_q, e_q;
  logic signed [SCORE_W-1:0] sc_q;
  logic                      need_s_q, need_e_q, need_a_q;
  logic [1:0]                status_q;
  piece_t                    cur_q;

  logic                      out_valid_q, out_pvalid_q, out_last_q;
  logic [1:0]                out_status_q;
  piece_t                    out_piece_q;

  cell_ctrl_t                ctrl;
  piece_t                    pc    [MAX_PIECES];
  cell_flag_t                flag  [MAX_PIECES];
  logic                      mark  [MAX_PIECES];
  logic                      below [MAX_PIECES+1];

  logic any_ge_s, any_hit_s, any_split_s, any_le_e, any_split_e;
  logic s_gt_e, has_room, merge, can_emit, fl_last_emit, emit_now;
  logic [CNT_W:0] need_total;

  // cell chain
  assign below[0] = 1'b0;
  for (genvar i = 0; i < MAX_PIECES; i++) begin : g_cell
    imsp_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctrl_i      (ctrl),
      .left_i      ((i == 0) ? piece_t'('0) : pc[(i == 0) ? 0 : i-1]),
      .right_i     ((i == MAX_PIECES-1) ? piece_t'('0) : pc[(i == MAX_PIECES-1) ? i : i+1]),
      .left_mark_i ((i == 0) ? 1'b0 : mark[(i == 0) ? 0 : i-1]),
      .below_i     (below[i]),
      .piece_o     (pc[i]),
      .mark_o      (mark[i]),
      .below_o     (below[i+1]),
      .flag_o      (flag[i])
    );
  end

  // gather cell flags
  always_comb begin
    any_ge_s    = 1'b0;
    any_hit_s   = 1'b0;
    any_split_s = 1'b0;
    any_le_e    = 1'b0;
    any_split_e = 1'b0;
    for (int i = 0; i < MAX_PIECES; i++) begin
      any_ge_s    = any_ge_s    | flag[i].ge_s;
      any_hit_s   = any_hit_s   | flag[i].hit_s;
      any_split_s = any_split_s | flag[i].split_s;
      any_le_e    = any_le_e    | flag[i].le_e;
      any_split_e = any_split_e | flag[i].split_e;
    end
  end

  // decode and flush helpers
  always_comb begin
    s_gt_e       = s_q > e_q;
    has_room     = cnt_q < CNT_W'(MAX_PIECES);
    need_total   = {1'b0, cnt_q} + (CNT_W+1)'(any_split_s) + (CNT_W+1)'(any_split_e)
                   + (CNT_W+1)'(!any_le_e);
    can_emit     = !out_valid_q || out_ready_i;
    merge        = (cur_q.hi != '1) && (pc[0].lo == cur_q.hi + 1'b1) &&
                   (pc[0].score == cur_q.score);
    fl_last_emit = (state_q == S_FL_RUN) && (cnt_q == '0) && can_emit;
    emit_now     = can_emit && ((state_q == S_EMIT) ||
                   ((state_q == S_FL_RUN) && ((cnt_q == '0) || !merge)));
  end

  // command to the cells
  always_comb begin
    ctrl.cnt = cnt_q;
    ctrl.s   = s_q;
    ctrl.e   = e_q;
    ctrl.sc  = sc_q;
    ctrl.cmd = CMD_HOLD;
    unique case (state_q)
      S_EVAL:     if (!s_gt_e && !any_ge_s && has_room) ctrl.cmd = CMD_LOAD_NEW;
      S_SPLIT_S:  if (need_s_q) ctrl.cmd = CMD_SPLIT_S;
      S_SPLIT_E:  if (need_e_q) ctrl.cmd = CMD_SPLIT_E;
      S_APPEND:   if (need_a_q) ctrl.cmd = CMD_APPEND;
      S_RAISE:    ctrl.cmd = CMD_RAISE;
      S_FL_START: if (cnt_q != '0) ctrl.cmd = CMD_SHIFT_DN;
      S_FL_RUN:   if (cnt_q != '0 && (merge || can_emit)) ctrl.cmd = CMD_SHIFT_DN;
      default:    ctrl.cmd = CMD_HOLD;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // controller and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      s_q          <= '0;
      e_q          <= '0;
      sc_q         <= '0;
      need_s_q     <= 1'b0;
      need_e_q     <= 1'b0;
      need_a_q     <= 1'b0;
      status_q     <= ST_OK;
      cur_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_pvalid_q <= 1'b0;
      out_piece_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (emit_now) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            s_q     <= seg_start_i;
            e_q     <= seg_end_i;
            sc_q    <= seg_score_i;
            state_q <= (req_type_i == REQ_FLUSH) ? S_FL_START : S_EVAL;
          end
        end
        S_EVAL: begin
          need_s_q <= any_split_s;
          need_e_q <= any_split_e;
          need_a_q <= !any_le_e;
          state_q  <= S_EMIT;
          if (s_gt_e) status_q <= ST_BAD;
          else if (!any_ge_s) begin
            if (has_room) begin
              status_q <= ST_OK;
              cnt_q    <= cnt_q + 1'b1;
            end else status_q <= ST_FULL;
          end
          else if (!any_hit_s) status_q <= ST_BAD;
          else if (need_total > (CNT_W+1)'(MAX_PIECES)) status_q <= ST_FULL;
          else begin
            status_q <= ST_OK;
            state_q  <= S_SPLIT_S;
          end
        end
        S_SPLIT_S: begin
          if (need_s_q) cnt_q <= cnt_q + 1'b1;
          state_q <= S_SPLIT_E;
        end
        S_SPLIT_E: begin
          if (need_e_q) cnt_q <= cnt_q + 1'b1;
          state_q <= S_APPEND;
        end
        S_APPEND: begin
          if (need_a_q) cnt_q <= cnt_q + 1'b1;
          state_q <= S_RAISE;
        end
        S_RAISE: state_q <= S_EMIT;
        S_EMIT: begin
          if (can_emit) begin
            out_status_q <= status_q;
            out_pvalid_q <= 1'b0;
            out_piece_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_FL_START: begin
          if (cnt_q == '0) begin
            status_q <= ST_OK;
            state_q  <= S_EMIT;
          end else begin
            cur_q   <= pc[0];
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_FL_RUN;
          end
        end
        S_FL_RUN: begin
          if (cnt_q == '0) begin
            if (can_emit) begin
              out_status_q <= ST_OK;
              out_pvalid_q <= 1'b1;
              out_piece_q  <= cur_q;
              out_last_q   <= 1'b1;
              state_q      <= S_IDLE;
            end
          end else if (merge) begin
            cur_q.hi <= pc[0].hi;
            cnt_q    <= cnt_q - 1'b1;
          end else if (can_emit) begin
            out_status_q <= ST_OK;
            out_pvalid_q <= 1'b1;
            out_piece_q  <= cur_q;
            out_last_q   <= 1'b0;
            cur_q        <= pc[0];
            cnt_q        <= cnt_q - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign piece_valid_o = out_pvalid_q;
  assign piece_start_o = out_piece_q.lo;
  assign piece_end_o   = out_piece_q.hi;
  assign piece_score_o = out_piece_q.score;
  assign last_o        = out_last_q;

  // checks
  `IMSP_ASSERT(a_cnt_cap, cnt_q <= CNT_W'(MAX_PIECES))
  `IMSP_ASSERT(a_cnt_step, {1'b0, cnt_q} <= {1'b0, $past(cnt_q)} + 1'b1)
  `IMSP_ASSERT_NEXT(a_flush_clears, fl_last_emit, cnt_q == '0 && state_q == S_IDLE)

endmodule

>>> rtl/imsp_cell.sv
// one cell of the piece chain: holds one piece; loads, splits, appends, shifts and raises it
// depends on imsp_pkg
`timescale 1ns / 1ps

module imsp_cell (
  input  logic                       clk_i,
  input  logic [imsp_pkg::IDX_W-1:0] idx_i,
  input  imsp_pkg::cell_ctrl_t       ctrl_i,
  input  imsp_pkg::piece_t           left_i,
  input  imsp_pkg::piece_t           right_i,
  input  logic                       left_mark_i,
  input  logic                       below_i,
  output imsp_pkg::piece_t           piece_o,
  output logic                       mark_o,
  output logic                       below_o,
  output imsp_pkg::cell_flag_t       flag_o
);
  import imsp_pkg::*;

  piece_t piece_q, piece_d;
  logic   active, at_cnt;

  // compares against the current word
  always_comb begin
    active          = CNT_W'(idx_i) < ctrl_i.cnt;
    at_cnt          = CNT_W'(idx_i) == ctrl_i.cnt;
    flag_o.ge_s     = active && (piece_q.hi >= ctrl_i.s);
    flag_o.hit_s    = flag_o.ge_s && (piece_q.lo <= ctrl_i.s);
    flag_o.split_s  = flag_o.hit_s && (piece_q.lo != ctrl_i.s);
    flag_o.le_e     = active && (piece_q.hi >= ctrl_i.e);
    flag_o.split_e  = flag_o.le_e && (piece_q.lo <= ctrl_i.e) && (piece_q.hi != ctrl_i.e);
    mark_o          = (ctrl_i.cmd == CMD_SPLIT_E) ? flag_o.split_e : flag_o.split_s;
    below_o         = below_i | mark_o;
  end

  // next piece
  always_comb begin
    piece_d = piece_q;
    case (ctrl_i.cmd)
      CMD_LOAD_NEW: begin
        if (at_cnt) piece_d = '{lo: ctrl_i.s, hi: ctrl_i.e, score: ctrl_i.sc};
      end
      CMD_SPLIT_S: begin
        if (mark_o) piece_d.hi = ctrl_i.s - 1'b1;
        else if (left_mark_i) piece_d = '{lo: ctrl_i.s, hi: left_i.hi, score: left_i.score};
        else if (below_i) piece_d = left_i;
      end
      CMD_SPLIT_E: begin
        if (mark_o) piece_d.hi = ctrl_i.e;
        else if (left_mark_i) begin
          piece_d = '{lo: ctrl_i.e + 1'b1, hi: left_i.hi, score: left_i.score};
        end
        else if (below_i) piece_d = left_i;
      end
      CMD_APPEND: begin
        if (at_cnt) piece_d = '{lo: left_i.hi + 1'b1, hi: ctrl_i.e, score: ctrl_i.sc};
      end
      CMD_RAISE: begin
        if (active && piece_q.lo >= ctrl_i.s && piece_q.hi <= ctrl_i.e &&
            ctrl_i.sc > piece_q.score) piece_d.score = ctrl_i.sc;
      end
      CMD_SHIFT_DN: piece_d = right_i;
      default: piece_d = piece_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    piece_q <= piece_d;
  end

  assign piece_o = piece_q;

endmodule
